FILE: rtl/lras_pkg.sv
`default_nettype none

package lras_pkg;

    // Width of the recency stamps kept per slot; wide enough never to wrap in use.
    localparam int unsigned STAMP_BITS = 40;

    typedef enum logic [2:0] {
        CMD_GET     = 3'd0,
        CMD_TRY_GET = 3'd1,
        CMD_PUT     = 3'd2,
        CMD_CHANGED = 3'd3,
        CMD_DEL     = 3'd4,
        CMD_SET     = 3'd5,
        CMD_FIND    = 3'd6,
        CMD_RESET   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_RECYCLED = 3'd1,
        STS_NOTFOUND = 3'd2,
        STS_STARVING = 3'd3,
        STS_BLOCKED  = 3'd4,
        STS_BAD      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PL_FREE = 2'd0,
        PL_LRU  = 2'd1,
        PL_USED = 2'd2,
        PL_HELD = 2'd3
    } t_place;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_rd;
        logic tgt_rd;
        logic exec;
    } t_dp_ctrl;

    typedef struct packed {
        logic cnt_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/lras_ctrl.sv
`default_nettype none

module lras_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [2:0]       i_command,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output lras_pkg::t_dp_ctrl    o_ctrl,
    input  wire lras_pkg::t_dp_stat i_stat
);
    import lras_pkg::*;

    t_state r_state, n_state;
    logic   r_clr_reply, n_clr_reply;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_reply <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_reply <= n_clr_reply;
            r_out_vld   <= n_out_vld;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_reply = r_clr_reply;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clr_wr = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = r_clr_reply ? ST_EXEC : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    case (t_cmd'(i_command))
                        CMD_RESET: begin
                            n_state     = ST_CLEAR;
                            n_clr_reply = 1'b1;
                        end
                        CMD_GET, CMD_TRY_GET, CMD_FIND: n_state = ST_SCAN;
                        default: n_state = ST_READ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctrl.scan_rd = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: n_state = ST_READ;
            ST_READ: begin
                o_ctrl.tgt_rd = 1'b1;
                n_state       = ST_EXEC;
            end
            ST_EXEC: begin
                if (!r_out_vld || i_out_ready) begin
                    o_ctrl.exec = 1'b1;
                    n_clr_reply = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_ctrl.exec) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

FILE: rtl/lras_datapath.sv
`default_nettype none

module lras_datapath #(
    parameter int unsigned ENTRIES    = 64,
    parameter int unsigned LABEL_BITS = 32,
    parameter int unsigned REF_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lras_pkg::t_dp_ctrl i_ctrl,
    output lras_pkg::t_dp_stat      o_stat,
    input  wire logic [2:0]         i_command,
    input  wire logic [31:0]        i_label,
    input  wire logic [7:0]         i_slot_index,
    output logic [2:0]              o_status,
    output logic [7:0]              o_entry_index,
    output logic [31:0]             o_entry_label,
    output logic [15:0]             o_ref_count,
    output logic [8:0]              o_used_count
);
    import lras_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned SB    = STAMP_BITS;
    localparam int unsigned BS_LO = 0;
    localparam int unsigned LS_LO = SB;
    localparam int unsigned PL_LO = 2 * SB;
    localparam int unsigned RF_LO = PL_LO + 2;
    localparam int unsigned LB_LO = RF_LO + REF_BITS;
    localparam int unsigned REC_W = LB_LO + LABEL_BITS;

    localparam logic [LABEL_BITS-1:0] FREE_MARK = {LABEL_BITS{1'b1}};
    localparam logic [REF_BITS-1:0]   REF_MAX   = {REF_BITS{1'b1}};

    logic [REC_W-1:0] mem [ENTRIES];

    t_cmd                  r_cmd;
    logic [LABEL_BITS-1:0] r_lab;
    logic [7:0]            r_slot;
    logic [IDX_W-1:0]      r_cnt;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [REC_W-1:0]      r_rdata;
    logic                  r_hit_vld, r_fr_vld, r_lru_vld;
    logic [IDX_W-1:0]      r_hit_idx, r_fr_idx, r_lru_idx;
    logic [SB-1:0]         r_hit_stamp, r_fr_stamp, r_lru_stamp;
    logic [IDX_W-1:0]      r_tgt;
    logic                  r_starv, r_dirty;
    logic [IDX_W-1:0]      r_chg;
    logic [LABEL_BITS-1:0] r_pend;
    logic [8:0]            r_used;
    logic [SB-1:0]         r_stamp;
    logic [2:0]            r_o_status;
    logic [7:0]            r_o_idx;
    logic [31:0]           r_o_lab;
    logic [15:0]           r_o_refs;
    logic [8:0]            r_o_used;

    // fields of the slot record last read
    logic [LABEL_BITS-1:0] q_lab;
    logic [REF_BITS-1:0]   q_refs;
    t_place                q_place;
    logic [SB-1:0]         q_ls, q_bs;

    assign q_lab   = r_rdata[LB_LO +: LABEL_BITS];
    assign q_refs  = r_rdata[RF_LO +: REF_BITS];
    assign q_place = t_place'(r_rdata[PL_LO +: 2]);
    assign q_ls    = r_rdata[LS_LO +: SB];
    assign q_bs    = r_rdata[BS_LO +: SB];

    assign o_stat.cnt_last = (r_cnt == IDX_W'(ENTRIES - 1));

    // scan: newest matching label, top of free stack, tail of LRU
    logic labelled, hit_better, fr_better, lru_better;
    assign labelled   = (q_place == PL_LRU) || (q_place == PL_USED);
    assign hit_better = r_rd_vld && labelled && (q_lab == r_lab) &&
                        (!r_hit_vld || (q_bs > r_hit_stamp));
    assign fr_better  = r_rd_vld && (q_place == PL_FREE) &&
                        (!r_fr_vld || (q_ls > r_fr_stamp));
    assign lru_better = r_rd_vld && (q_place == PL_LRU) &&
                        (!r_lru_vld || (q_ls < r_lru_stamp));

    logic             s_ok;
    logic [IDX_W-1:0] n_tgt;
    assign s_ok = ({1'b0, r_slot} < 9'(ENTRIES));

    always_comb begin
        case (r_cmd)
            CMD_GET, CMD_TRY_GET, CMD_FIND: begin
                if (r_hit_vld) begin
                    n_tgt = r_hit_idx;
                end else if (r_fr_vld) begin
                    n_tgt = r_fr_idx;
                end else begin
                    n_tgt = r_lru_idx;
                end
            end
            default: n_tgt = r_slot[IDX_W-1:0];
        endcase
    end

    // execute step
    logic                  n_wr, n_ret, n_stamp_inc;
    logic [LABEL_BITS-1:0] n_lab;
    logic [REF_BITS-1:0]   n_refs;
    t_place                n_place;
    logic [SB-1:0]         n_ls, n_bs;
    t_status               n_status;
    logic                  n_starv, n_dirty, n_chg_ld;
    logic [LABEL_BITS-1:0] n_pend;
    logic [8:0]            n_used;
    logic [SB-1:0]         n_stamp;

    always_comb begin
        n_wr        = 1'b0;
        n_ret       = 1'b1;
        n_stamp_inc = 1'b0;
        n_lab       = q_lab;
        n_refs      = q_refs;
        n_place     = q_place;
        n_ls        = q_ls;
        n_bs        = q_bs;
        n_status    = STS_OK;
        n_starv     = r_starv;
        n_dirty     = r_dirty;
        n_chg_ld    = 1'b0;
        n_pend      = r_pend;
        n_used      = r_used;
        n_stamp     = r_stamp;
        case (r_cmd)
            CMD_GET, CMD_TRY_GET: begin
                if (r_starv) begin
                    n_status = STS_STARVING;
                    n_ret    = 1'b0;
                end else if (r_hit_vld) begin
                    if (q_refs == REF_MAX) begin
                        n_status = STS_BAD;
                        n_ret    = 1'b0;
                    end else begin
                        n_refs  = q_refs + 1'b1;
                        n_place = PL_USED;
                        n_wr    = 1'b1;
                        if (q_refs == '0) begin
                            n_used = r_used + 9'd1;
                        end
                    end
                end else if (r_cmd == CMD_TRY_GET) begin
                    n_status = STS_NOTFOUND;
                    n_ret    = 1'b0;
                end else if (!r_fr_vld && !r_lru_vld) begin
                    n_starv  = 1'b1;
                    n_status = STS_STARVING;
                    n_ret    = 1'b0;
                end else if (r_dirty) begin
                    n_status = STS_BLOCKED;
                    n_ret    = 1'b0;
                end else begin
                    n_dirty  = 1'b1;
                    n_place  = PL_HELD;
                    n_refs   = REF_BITS'(1);
                    n_used   = r_used + 9'd1;
                    n_starv  = 1'b0;
                    n_chg_ld = 1'b1;
                    n_pend   = r_lab;
                    n_status = STS_RECYCLED;
                    n_wr     = 1'b1;
                end
            end
            CMD_PUT: begin
                if (!s_ok || (q_refs == '0) || (q_place == PL_HELD)) begin
                    n_status = STS_BAD;
                    n_ret    = 1'b0;
                end else begin
                    n_refs = q_refs - 1'b1;
                    n_wr   = 1'b1;
                    if (q_refs == REF_BITS'(1)) begin
                        n_place     = PL_LRU;
                        n_ls        = r_stamp;
                        n_stamp_inc = 1'b1;
                        n_used      = r_used - 9'd1;
                        n_starv     = 1'b0;
                    end
                end
            end
            CMD_CHANGED: begin
                if (!r_dirty || !s_ok || (r_tgt != r_chg)) begin
                    n_status = STS_BAD;
                    n_ret    = 1'b0;
                end else begin
                    n_lab       = r_pend;
                    n_place     = PL_USED;
                    n_bs        = r_stamp;
                    n_stamp_inc = 1'b1;
                    n_pend      = FREE_MARK;
                    n_dirty     = 1'b0;
                    n_wr        = 1'b1;
                end
            end
            CMD_DEL: begin
                if (!s_ok || (q_refs != '0)) begin
                    n_status = STS_BAD;
                    n_ret    = 1'b0;
                end else begin
                    n_lab       = FREE_MARK;
                    n_place     = PL_FREE;
                    n_ls        = r_stamp;
                    n_stamp_inc = 1'b1;
                    n_wr        = 1'b1;
                end
            end
            CMD_SET: begin
                if (!s_ok) begin
                    n_ret = 1'b0;
                end else if (q_place == PL_HELD) begin
                    n_status = STS_BAD;
                    n_ret    = 1'b0;
                end else begin
                    n_lab       = r_lab;
                    n_bs        = r_stamp;
                    n_stamp_inc = 1'b1;
                    n_wr        = 1'b1;
                    if (q_refs != '0) begin
                        n_place = PL_USED;
                    end else begin
                        n_place = PL_LRU;
                        n_ls    = r_stamp;
                    end
                end
            end
            CMD_FIND: begin
                if (!r_hit_vld) begin
                    n_status = STS_NOTFOUND;
                    n_ret    = 1'b0;
                end
            end
            default: begin
                n_ret   = 1'b0;
                n_starv = 1'b0;
                n_dirty = 1'b0;
                n_pend  = FREE_MARK;
                n_used  = 9'd0;
                n_stamp = SB'(ENTRIES);
            end
        endcase
        if (n_stamp_inc) begin
            n_stamp = r_stamp + 1'b1;
        end
    end

    logic [31:0] n_refs32;
    assign n_refs32 = 32'(n_refs);

    // slot memory: one read and one write port, registered read
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [REC_W-1:0] wdata;

    assign rd_en   = i_ctrl.scan_rd || i_ctrl.tgt_rd;
    assign rd_addr = i_ctrl.tgt_rd ? n_tgt : r_cnt;
    assign wr_en   = i_ctrl.clr_wr || (i_ctrl.exec && n_wr);
    assign wr_addr = i_ctrl.clr_wr ? r_cnt : r_tgt;

    always_comb begin
        if (i_ctrl.clr_wr) begin
            wdata = {FREE_MARK, {REF_BITS{1'b0}}, PL_FREE, SB'(r_cnt), {SB{1'b0}}};
        end else begin
            wdata = {n_lab, n_refs, n_place, n_ls, n_bs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wdata;
        end
    end

    // request capture and scan results
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_lab  <= i_label[LABEL_BITS-1:0];
            r_slot <= i_slot_index;
        end
        r_rd_idx <= r_cnt;
        if (hit_better) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_stamp <= q_bs;
        end
        if (fr_better) begin
            r_fr_idx   <= r_rd_idx;
            r_fr_stamp <= q_ls;
        end
        if (lru_better) begin
            r_lru_idx   <= r_rd_idx;
            r_lru_stamp <= q_ls;
        end
        if (i_ctrl.tgt_rd) begin
            r_tgt <= n_tgt;
        end
        if (i_ctrl.exec && n_chg_ld) begin
            r_chg <= r_tgt;
        end
        if (i_ctrl.exec) begin
            r_o_status <= n_status;
            r_o_idx    <= n_ret ? 8'(r_tgt) : 8'd0;
            r_o_lab    <= n_ret ? 32'(n_lab) : 32'd0;
            r_o_refs   <= n_ret ? n_refs32[15:0] : 16'd0;
            r_o_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit_vld <= 1'b0;
            r_fr_vld  <= 1'b0;
            r_lru_vld <= 1'b0;
            r_starv   <= 1'b0;
            r_dirty   <= 1'b0;
            r_pend    <= FREE_MARK;
            r_used    <= 9'd0;
            r_stamp   <= SB'(ENTRIES);
        end else begin
            r_rd_vld <= i_ctrl.scan_rd;
            if (i_ctrl.load) begin
                r_cnt     <= '0;
                r_hit_vld <= 1'b0;
                r_fr_vld  <= 1'b0;
                r_lru_vld <= 1'b0;
            end else begin
                if (i_ctrl.clr_wr || i_ctrl.scan_rd) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (hit_better) begin
                    r_hit_vld <= 1'b1;
                end
                if (fr_better) begin
                    r_fr_vld <= 1'b1;
                end
                if (lru_better) begin
                    r_lru_vld <= 1'b1;
                end
            end
            if (i_ctrl.exec) begin
                r_starv <= n_starv;
                r_dirty <= n_dirty;
                r_pend  <= n_pend;
                r_used  <= n_used;
                r_stamp <= n_stamp;
            end
        end
    end

    assign o_status      = r_o_status;
    assign o_entry_index = r_o_idx;
    assign o_entry_label = r_o_lab;
    assign o_ref_count   = r_o_refs;
    assign o_used_count  = r_o_used;

endmodule

`default_nettype wire

FILE: rtl/refcounted_lru_active_set.sv
// Get, try_get and find scan the slot records (one slot record read per cycle), close
// the scan, then do a target read and the update; put, changed, del and set do only
// the target read and the update; the reset command runs the clearing pass, then the
// update. One request at a time: the next can be accepted once the result registers,
// and the update waits while a held result is not taken. Reset: synchronous, active
// low; a clearing pass then initializes the slot memory, with no request accepted until done.
`default_nettype none

module refcounted_lru_active_set #(
    parameter int unsigned ENTRIES    = 64,
    parameter int unsigned LABEL_BITS = 32,
    parameter int unsigned REF_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_label,
    input  wire logic [7:0]  i_slot_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_entry_index,
    output logic [31:0]      o_entry_label,
    output logic [15:0]      o_ref_count,
    output logic [8:0]       o_used_count
);
    import lras_pkg::*;

    // Slots live in one memory of records: label, count, list place, list stamp and
    // label stamp. Instead of linked lists, each slot carries the stamp of its last
    // list push; the free-stack top is the free slot with the largest stamp, the LRU
    // tail the LRU slot with the smallest. Duplicate labels resolve to the slot with
    // the newest label stamp. All three are found in one pass over the memory.

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    // Sequence each request: capture, scan (get, try_get and find), target read, update; reset clears instead.
    lras_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (ctrl),
        .i_stat      (stat)
    );

    // Hold slot memory, flags and the result beat.
    lras_datapath #(
        .ENTRIES    (ENTRIES),
        .LABEL_BITS (LABEL_BITS),
        .REF_BITS   (REF_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_label       (i_label),
        .i_slot_index  (i_slot_index),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_entry_label (o_entry_label),
        .o_ref_count   (o_ref_count),
        .o_used_count  (o_used_count)
    );

endmodule

`default_nettype wire

FILE: rtl/lras_checker.sv
`default_nettype none

module lras_checker #(
    parameter int unsigned ENTRIES = 64
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_entry_index,
    input wire logic [31:0] o_entry_label,
    input wire logic [15:0] o_ref_count,
    input wire logic [8:0]  o_used_count
);
    import lras_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result beat dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_used_count <= 9'(ENTRIES))
        else $error("used count exceeds slot count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_NOTFOUND || o_status == STS_STARVING ||
                        o_status == STS_BLOCKED || o_status == STS_BAD)
        |-> o_entry_index == 8'd0 && o_entry_label == 32'd0 && o_ref_count == 16'd0)
        else $error("error result carries slot data");

    a_recycle_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STS_RECYCLED |-> o_ref_count == 16'd1)
        else $error("recycled slot count is not one");

endmodule

bind refcounted_lru_active_set lras_checker #(.ENTRIES(ENTRIES)) u_lras_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_index (o_entry_index),
    .o_entry_label (o_entry_label),
    .o_ref_count   (o_ref_count),
    .o_used_count  (o_used_count)
);

`default_nettype wire
